[src/mss_pkg.sv]
// Shared operation codes, status codes and control structs for the min-tracking stack.
package mss_pkg;

   // Operation codes carried on req_tuser
   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_POP  = 2'd1;
   localparam logic [1:0] MODE_PEEK = 2'd2;

   // Status codes carried on rsp_tuser
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic capture;  // latch the incoming transaction
      logic exec;     // perform the operation and load the result register
      logic refill;   // load the cached top from the memory read data
   } mss_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic refill_needed;  // pop left entries behind, top cache must reload
      logic rsp_blocked;    // result register holds a transaction not yet taken
   } mss_stat_type;

endpackage

[src/mss_ctrl.sv]
// Controller state machine: sequences capture, execute and top-cache refill.
module mss_ctrl
   import mss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  mss_stat_type stat,
   output mss_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REFILL
   } state_type;

   state_type state_ff;
   state_type state_in;

   // A captured transaction may wait in EXEC until the result register frees up
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.capture = req_tvalid && req_tready;
      cmd.exec    = (state_ff == ST_EXEC) && !stat.rsp_blocked;
      cmd.refill  = (state_ff == ST_REFILL);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.exec) begin
               state_in = stat.refill_needed ? ST_REFILL : ST_IDLE;
            end
         end
         ST_REFILL: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/mss_datapath.sv]
// Datapath: entry memory, cached top entry, running minimum, count and result register.
module mss_datapath
   import mss_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 16,
   localparam int CW      = $clog2(DEPTH + 1),
   localparam int IN_W    = ((DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W   = ((2 * DATA_WIDTH + 1 + CW + 7) / 8) * 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  mss_cmd_type        cmd,
   output mss_stat_type       stat,
   input  logic [IN_W-1:0]    req_tdata,
   input  logic [1:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   output logic [1:0]         rsp_tuser
);

   localparam int DW = DATA_WIDTH;
   localparam int EW = DATA_WIDTH + 2;   // room for the 2*v - min code
   localparam int AW = $clog2(DEPTH);

   // Entry memory, written on push, read one below the top on pop
   logic signed [EW-1:0] mem [DEPTH];
   logic signed [EW-1:0] rd_data_ff;

   logic [1:0]           mode_ff;
   logic signed [DW-1:0] value_ff;
   logic [CW-1:0]        count_ff;
   logic signed [DW-1:0] min_ff;
   logic signed [EW-1:0] top_ff;

   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_value_ff;
   logic signed [DW-1:0] rsp_min_ff;
   logic                 rsp_empty_ff;
   logic [1:0]           rsp_status_ff;
   logic [CW-1:0]        rsp_count_ff;

   logic [CW-1:0]        count_in;
   logic signed [DW-1:0] min_in;
   logic signed [EW-1:0] top_in;
   logic signed [DW-1:0] res_value;
   logic [1:0]           res_status;
   logic                 wr_en;
   logic signed [EW-1:0] wr_data;
   logic                 refill_needed;

   logic signed [EW-1:0] v_ext;
   logic signed [EW-1:0] min_ext;
   logic signed [EW-1:0] enc_code;
   logic signed [EW-1:0] restore_min;
   logic signed [DW-1:0] top_val;
   logic                 top_gt;
   logic                 empty;
   logic                 full;
   logic [AW-1:0]        wr_addr;
   logic [CW-1:0]        rd_index;
   logic [AW-1:0]        rd_addr;

   assign v_ext       = {{2{value_ff[DW-1]}}, value_ff};
   assign min_ext     = {{2{min_ff[DW-1]}}, min_ff};
   assign enc_code    = (v_ext <<< 1) - min_ext;
   assign restore_min = (min_ext <<< 1) - top_ff;
   // An entry above the minimum holds its plain value; otherwise the minimum is the top value
   assign top_gt      = top_ff > min_ext;
   assign top_val     = top_gt ? top_ff[DW-1:0] : min_ff;
   assign empty       = (count_ff == '0);
   assign full        = (count_ff == CW'(DEPTH));
   assign wr_addr     = count_ff[AW-1:0];
   assign rd_index    = count_ff - CW'(2);
   assign rd_addr     = rd_index[AW-1:0];

   always_comb begin
      count_in      = count_ff;
      min_in        = min_ff;
      top_in        = top_ff;
      res_value     = '1;
      res_status    = STATUS_OK;
      wr_en         = 1'b0;
      wr_data       = v_ext;
      refill_needed = 1'b0;
      case (mode_ff)
         MODE_PUSH: begin
            if (full) begin
               res_status = STATUS_FULL;
               res_value  = top_val;
            end else begin
               wr_en     = 1'b1;
               count_in  = count_ff + CW'(1);
               res_value = value_ff;
               if (empty) begin
                  wr_data = v_ext;
                  min_in  = value_ff;
               end else if (value_ff < min_ff) begin
                  wr_data = enc_code;
                  min_in  = value_ff;
               end else begin
                  wr_data = v_ext;
               end
               top_in = wr_data;
            end
         end
         MODE_POP: begin
            if (empty) begin
               res_status = STATUS_EMPTY;
            end else begin
               res_value = top_val;
               if (!top_gt) begin
                  min_in = restore_min[DW-1:0];
               end
               count_in      = count_ff - CW'(1);
               refill_needed = (count_ff != CW'(1));
            end
         end
         default: begin
            // peek; the unused code behaves the same
            if (empty) begin
               res_status = STATUS_EMPTY;
            end else begin
               res_value = top_val;
            end
         end
      endcase
   end

   always_comb begin
      stat.refill_needed = cmd.exec && refill_needed;
      stat.rsp_blocked   = rsp_valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         min_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            count_ff     <= count_in;
            min_ff       <= min_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_tuser;
         value_ff <= req_tdata[DW-1:0];
      end
      if (cmd.exec) begin
         top_ff        <= top_in;
         rsp_value_ff  <= res_value;
         rsp_min_ff    <= (count_in == '0) ? '1 : min_in;
         rsp_empty_ff  <= (count_in == '0);
         rsp_status_ff <= res_status;
         rsp_count_ff  <= count_in;
      end else if (cmd.refill) begin
         top_ff <= rd_data_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_empty_ff, rsp_min_ff, rsp_value_ff});
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !rsp_valid_ff || rsp_tready)
      else $error("result register overwritten before it was taken");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_FULL) |-> rsp_count_ff == CW'(DEPTH))
      else $error("full status reported below capacity");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_empty_ff == (rsp_count_ff == '0))
      else $error("empty flag disagrees with entry count");

   a_refill_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.refill |-> count_ff != '0)
      else $error("top cache refill with an empty stack");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");
`endif

endmodule

[src/min_tracking_stack.sv]
// Top level of the min-tracking stack: controller plus datapath.
//
// Each request transaction is a push, pop or peek on a bounded signed stack that also
// reports the current minimum with a single minimum register. After acceptance a push,
// peek or refused push passes through EXEC and the controller returns to IDLE for the next
// request; a pop that leaves entries behind also passes through REFILL because the cached top entry is reloaded
// through the entry memory's registered read port. A result waits in its own output
// register, and the next request is accepted while it waits, but not a second one.
module min_tracking_stack
   import mss_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 16,
   localparam int CW      = $clog2(DEPTH + 1),
   localparam int IN_W    = ((DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W   = ((2 * DATA_WIDTH + 1 + CW + 7) / 8) * 8
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,   // push_value
   input  logic [1:0]       req_tuser,   // mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // result_value, current_min, is_empty, entry_count
   output logic [1:0]       rsp_tuser    // status
);

   mss_cmd_type  cmd;
   mss_stat_type stat;

   mss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mss_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[verif/min_tracking_stack_checker.sv]
// Checker for the min-tracking stack: predicts each result and compares it with the DUT.
module min_tracking_stack_checker
   import mss_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // push_value
   input  logic [1:0]  req_tuser,   // mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // result_value, current_min, is_empty, entry_count
   input  logic [1:0]  rsp_tuser,   // status
   output int          mismatch_count,
   output int          pending_count
);

   localparam int AW = $clog2(DEPTH);

   typedef struct packed {
      logic [15:0] value;
      logic [15:0] min;
      logic        empty;
      logic [1:0]  status;
      logic [6:0]  count;
   } stack_result_type;

   // Entries hold either a plain value or the 2*value-min code, so two extra bits.
   logic signed [17:0] stack_mem [DEPTH];
   logic [6:0]         stack_fill;
   logic signed [15:0] stack_min;
   stack_result_type   expected_results [$];

   function automatic logic signed [15:0] top_of_stack();
      logic signed [17:0] code;
      code = stack_mem[AW'(stack_fill - 7'd1)];
      return (code > stack_min) ? code[15:0] : stack_min;
   endfunction

   function automatic stack_result_type apply_op(logic [1:0] mode,
                                                 logic signed [15:0] push_value);
      stack_result_type   r;
      logic signed [17:0] code;
      r.value  = 16'hffff;
      r.status = STATUS_OK;
      case (mode)
         MODE_PUSH: begin
            if (stack_fill == DEPTH) begin
               r.status = STATUS_FULL;
               r.value  = top_of_stack();
            end else begin
               if (stack_fill == 0) begin
                  stack_mem[0] = {{2{push_value[15]}}, push_value};
                  stack_min    = push_value;
               end else if (push_value < stack_min) begin
                  stack_mem[stack_fill[AW-1:0]] = 18'(2 * push_value - stack_min);
                  stack_min                     = push_value;
               end else begin
                  stack_mem[stack_fill[AW-1:0]] = {{2{push_value[15]}}, push_value};
               end
               stack_fill++;
               r.value = push_value;
            end
         end
         MODE_POP: begin
            if (stack_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               code = stack_mem[AW'(stack_fill - 7'd1)];
               if (code > stack_min) begin
                  r.value = code[15:0];
               end else begin
                  // entry was a new minimum: recover the one below it
                  r.value   = stack_min;
                  stack_min = 16'(2 * stack_min - code);
               end
               stack_fill--;
            end
         end
         default: begin
            // peek, and the unused code behaves the same
            if (stack_fill == 0) r.status = STATUS_EMPTY;
            else r.value = top_of_stack();
         end
      endcase
      r.min   = (stack_fill == 0) ? 16'hffff : stack_min;
      r.empty = (stack_fill == 0);
      r.count = stack_fill;
      return r;
   endfunction

   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      stack_result_type got;
      stack_result_type want;
      if (reset) begin
         stack_fill     = '0;
         stack_min      = '0;
         mismatch_count = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.value  = rsp_tdata[15:0];
            got.min    = rsp_tdata[31:16];
            got.empty  = rsp_tdata[32];
            got.count  = rsp_tdata[39:33];
            got.status = rsp_tuser;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result transaction, expected none, actual value %0d",
                        $time, $signed(got.value));
            end else begin
               want = expected_results.pop_front();
               compare_field("result_value", $signed(want.value), $signed(got.value));
               compare_field("current_min", $signed(want.min), $signed(got.min));
               compare_field("is_empty", want.empty, got.empty);
               compare_field("status", want.status, got.status);
               compare_field("entry_count", want.count, got.count);
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_op(req_tuser, $signed(req_tdata)));
      end
      pending_count = expected_results.size();
   end

endmodule

[verif/min_tracking_stack_tb.sv]
// Testbench top for the min-tracking stack: clock, reset, stimulus and verdict.
module min_tracking_stack_tb;
   import mss_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, handled as a peek
   localparam int         DEPTH       = 64;
   localparam int         TOTAL_OPS   = 1050;
   localparam int         CYCLE_LIMIT = 200000;
   localparam logic [15:0] VAL_MAX = 16'h7fff;
   localparam logic [15:0] VAL_MIN = 16'h8000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // push_value
   logic [1:0]  req_tuser  = MODE_PUSH;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // result_value, current_min, is_empty, entry_count
   logic [1:0]  rsp_tuser;   // status

   int mismatch_count;
   int pending_count;
   int cycle_count = 0;
   int ops_sent    = 0;
   int rsp_hold    = 0;    // long receiver stall requested by the sender side
   bit no_gaps     = 1'b0;

   min_tracking_stack i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   min_tracking_stack_checker #(.DEPTH(DEPTH)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Called and returns at a falling edge.
   task automatic send_op(logic [1:0] mode, logic [15:0] value);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      ops_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2, 3: return 16'($urandom_range(0, 16) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_op(int push_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_pct) send_op(MODE_PUSH, rand_value());
      else if (r < push_pct + (100 - push_pct) * 3 / 4) send_op(MODE_POP, rand_value());
      else if (r < 97) send_op(MODE_PEEK, rand_value());
      else send_op(MODE_SPARE, rand_value());
   endtask

   // Overfill so pushes get refused, then pop past empty.
   task automatic fill_and_empty();
      repeat (DEPTH + 3) send_op(MODE_PUSH, rand_value());
      send_op(MODE_PEEK, rand_value());
      repeat (DEPTH + 2) send_op(MODE_POP, rand_value());
   endtask

   // Pushes that keep falling until the 16-bit value wraps build a chain of encoded minimums.
   task automatic falling_chain();
      int          n;
      logic [15:0] v;
      n = $urandom_range(4, 20);
      v = rand_value();
      repeat (n) begin
         send_op(MODE_PUSH, v);
         v = v - 16'($urandom_range(1, 3000));
      end
      repeat (n) begin
         if ($urandom_range(0, 3) == 0) send_op(MODE_PEEK, rand_value());
         send_op(MODE_POP, rand_value());
      end
   endtask

   task automatic pressure_burst();
      rsp_hold = $urandom_range(40, 100);
      repeat ($urandom_range(6, 12)) random_op(50);
   endtask

   // receiver
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold) @(negedge clock);
            rsp_hold = 0;
         end
         gap = no_gaps ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // sender and verdict
   initial begin
      int n;
      int push_pct;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty stack answers
      send_op(MODE_POP, VAL_MAX);
      send_op(MODE_PEEK, VAL_MIN);
      send_op(MODE_SPARE, 16'hffff);
      // widest code: most negative value below the largest
      send_op(MODE_PUSH, VAL_MAX);
      send_op(MODE_PUSH, VAL_MIN);
      send_op(MODE_PUSH, VAL_MIN);     // equal to the minimum, stored plain
      send_op(MODE_PUSH, 16'hffff);
      send_op(MODE_PEEK, 16'h0);
      send_op(MODE_SPARE, 16'h0);
      send_op(MODE_POP, 16'h0);
      send_op(MODE_POP, 16'h0);
      send_op(MODE_POP, 16'h0);        // restores the old minimum
      send_op(MODE_PEEK, 16'h0);
      send_op(MODE_POP, 16'h0);
      send_op(MODE_POP, 16'h0);
      send_op(MODE_PUSH, VAL_MIN);
      send_op(MODE_PUSH, VAL_MAX);
      send_op(MODE_PUSH, 16'h0);
      send_op(MODE_PUSH, VAL_MIN);
      repeat (4) send_op(MODE_POP, 16'h5555);
      send_op(MODE_PUSH, 16'hfffb);
      send_op(MODE_POP, 16'haaaa);
      drain();

      fill_and_empty();
      drain();
      pressure_burst();
      drain();

      while (ops_sent < TOTAL_OPS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 19))
            0: fill_and_empty();
            1, 2: pressure_burst();
            3, 4: falling_chain();
            5: drain();
            default: begin
               n        = $urandom_range(10, 40);
               push_pct = $urandom_range(25, 75);
               repeat (n) random_op(push_pct);
            end
         endcase
      end
      no_gaps = 1'b0;
      drain();

      if (mismatch_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
